### rtl/alo_pkg.sv
// shared types and constants for the angle observer
package alo_pkg;

    // fixed field widths of the sample and estimate beats
    localparam int RAW_W     = 16;
    localparam int POS_OUT_W = 16;
    localparam int VEL_W     = 32;

    // configuration port geometry
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register widths and reset values
    localparam int L1_W    = 16;
    localparam int L2_W    = 32;
    localparam int STEP_W  = 32;
    localparam int LIMIT_W = 31;

    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 31'd768000;

    // register indexes, taken from paddr word bits
    typedef enum logic [1:0] {
        REG_L1_GAIN     = 2'd0,
        REG_L2_GAIN     = 2'd1,
        REG_STEP_GAIN   = 2'd2,
        REG_SPEED_LIMIT = 2'd3
    } reg_idx_t;

    // observer gains and clamp as seen by the datapath
    typedef struct packed {
        logic [L1_W-1:0]    l1_gain;
        logic [L2_W-1:0]    l2_gain;
        logic [STEP_W-1:0]  step_gain;
        logic [LIMIT_W-1:0] speed_limit;
    } cfg_t;

endpackage

### rtl/alo_stream_if.sv
// valid/ready channels for raw samples and observer estimates

interface alo_in_if;
    logic                       valid;
    logic                       ready;
    logic [alo_pkg::RAW_W-1:0]  raw_angle;

    modport source (output valid, output raw_angle, input ready);
    modport sink   (input valid, input raw_angle, output ready);
endinterface

interface alo_out_if;
    logic                              valid;
    logic                              ready;
    logic [alo_pkg::POS_OUT_W-1:0]     position;
    logic signed [alo_pkg::VEL_W-1:0]  velocity;

    modport source (output valid, output position, output velocity, input ready);
    modport sink   (input valid, input position, input velocity, output ready);
endinterface

### rtl/alo_regs.sv
// configuration register file behind the apb-style port
module alo_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [alo_pkg::APB_AW-1:0]   paddr,
    input  logic [alo_pkg::APB_DW-1:0]   pwdata,
    output logic [alo_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output alo_pkg::cfg_t                cfg
);

    alo_pkg::cfg_t     cfg_reg;
    alo_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = alo_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.l1_gain     <= '0;
            cfg_reg.l2_gain     <= '0;
            cfg_reg.step_gain   <= '0;
            cfg_reg.speed_limit <= alo_pkg::SPEED_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                alo_pkg::REG_L1_GAIN:     cfg_reg.l1_gain     <= pwdata[alo_pkg::L1_W-1:0];
                alo_pkg::REG_L2_GAIN:     cfg_reg.l2_gain     <= pwdata[alo_pkg::L2_W-1:0];
                alo_pkg::REG_STEP_GAIN:   cfg_reg.step_gain   <= pwdata[alo_pkg::STEP_W-1:0];
                alo_pkg::REG_SPEED_LIMIT: cfg_reg.speed_limit <= pwdata[alo_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            alo_pkg::REG_L1_GAIN:     prdata = alo_pkg::APB_DW'(cfg_reg.l1_gain);
            alo_pkg::REG_L2_GAIN:     prdata = alo_pkg::APB_DW'(cfg_reg.l2_gain);
            alo_pkg::REG_STEP_GAIN:   prdata = alo_pkg::APB_DW'(cfg_reg.step_gain);
            alo_pkg::REG_SPEED_LIMIT: prdata = alo_pkg::APB_DW'(cfg_reg.speed_limit);
            default:                  prdata = '0;
        endcase
    end

endmodule

### rtl/alo_update.sv
// one observer update: wrapped error, position advance, velocity clamp
module alo_update
#(
    parameter int ANGLE_BITS         = 16,
    parameter int POSITION_FRAC_BITS = 16
)
(
    input  logic [ANGLE_BITS-1:0]                     raw_a,
    input  logic [ANGLE_BITS+POSITION_FRAC_BITS-1:0]  pos,
    input  logic signed [alo_pkg::VEL_W-1:0]          vel,
    input  alo_pkg::cfg_t                             cfg,
    output logic [ANGLE_BITS+POSITION_FRAC_BITS-1:0]  pos_next,
    output logic signed [alo_pkg::VEL_W-1:0]          vel_next
);

    localparam int AW = ANGLE_BITS;
    localparam int PW = ANGLE_BITS + POSITION_FRAC_BITS;

    // drift term scale 2^(PW-40), correction term scale 2^(frac-16)
    localparam int DRIFT_SH = PW - 40;
    localparam int DRIFT_L  = (DRIFT_SH > 0) ? DRIFT_SH : 0;
    localparam int DRIFT_R  = (DRIFT_SH < 0) ? -DRIFT_SH : 0;
    localparam int CORR_SH  = POSITION_FRAC_BITS - 16;
    localparam int CORR_L   = (CORR_SH > 0) ? CORR_SH : 0;
    localparam int CORR_R   = (CORR_SH < 0) ? -CORR_SH : 0;

    logic [AW-1:0]                            diff;
    logic signed [AW-1:0]                     err;
    logic signed [63:0]                       drift_prod;
    logic signed [63:0]                       drift_sc;
    logic signed [AW+alo_pkg::L1_W:0]         corr_prod;
    logic signed [63:0]                       corr_sc;
    logic signed [AW+alo_pkg::L2_W:0]         gain_prod;
    logic signed [63:0]                       vel_sum;
    logic signed [63:0]                       lim_pos;
    logic signed [63:0]                       lim_neg;
    logic signed [63:0]                       vel_clamped;

    // shortest signed path: the modular difference read as two's complement
    assign diff = raw_a - pos[PW-1 -: AW];
    assign err  = signed'(diff);

    // position advance from the old velocity plus the error correction
    assign drift_prod = vel * signed'({1'b0, cfg.step_gain});
    assign drift_sc   = (drift_prod <<< DRIFT_L) >>> DRIFT_R;
    assign corr_prod  = err * signed'({1'b0, cfg.l1_gain});
    assign corr_sc    = (64'(corr_prod) <<< CORR_L) >>> CORR_R;
    assign pos_next   = pos + PW'(drift_sc) + PW'(corr_sc);

    // velocity correction, floored, then clamp to the speed limit
    assign gain_prod = err * signed'({1'b0, cfg.l2_gain});
    assign vel_sum   = 64'(vel) + 64'(gain_prod >>> 16);
    assign lim_pos   = signed'(64'(cfg.speed_limit));
    assign lim_neg   = -lim_pos;

    always_comb
    begin
        if (vel_sum > lim_pos)
            vel_clamped = lim_pos;
        else if (vel_sum < lim_neg)
            vel_clamped = lim_neg;
        else
            vel_clamped = vel_sum;
    end

    assign vel_next = alo_pkg::VEL_W'(vel_clamped);

endmodule

### rtl/angle_luenberger_observer_core.sv
// top level of the position/velocity observer with its register port
//
//  channel   dir  beat contents                   handshake
//  sample    in   raw_angle                       valid/ready
//  estimate  out  position, velocity              valid/ready
//  apb       in   l1, l2, step gains, limit       psel/penable, pready high
//
// one sample per cycle sustained while estimates are taken; a beat taken
// passes the sample register, then the update into the state registers,
// which double as the result register, before the estimate port.
// the update loop (error, multiply, add, clamp) is combinational.
// reset clears both estimates and loads the register defaults.
// a stalled estimate holds the state; an empty sample register takes one
// more beat, then sample ready drops until the estimate is taken.
module angle_luenberger_observer_core
#(
    parameter int ANGLE_BITS         = 16,
    parameter int POSITION_FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    alo_in_if.sink                      sample,
    alo_out_if.source                   estimate,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [alo_pkg::APB_AW-1:0]  paddr,
    input  logic [alo_pkg::APB_DW-1:0]  pwdata,
    output logic [alo_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int AW = ANGLE_BITS;
    localparam int PW = ANGLE_BITS + POSITION_FRAC_BITS;

    alo_pkg::cfg_t                      cfg;
    logic                               smp_valid_reg;
    logic [alo_pkg::RAW_W-1:0]          raw_reg;
    logic                               res_valid_reg;
    logic [PW-1:0]                      pos_reg;
    logic signed [alo_pkg::VEL_W-1:0]   vel_reg;
    logic [PW-1:0]                      pos_next;
    logic signed [alo_pkg::VEL_W-1:0]   vel_next;
    logic [AW-1:0]                      raw_a;
    logic                               advance;
    logic                               take;

    alo_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake: the update stage moves when the result slot is free or being taken
    assign advance      = !res_valid_reg || estimate.ready;
    assign sample.ready = !smp_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    // raw sample resized to the angle width
    assign raw_a = AW'({{AW{1'b0}}, raw_reg});

    alo_update
    #(
        .ANGLE_BITS         (ANGLE_BITS),
        .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
    )
    u_update
    (
        .raw_a    (raw_a),
        .pos      (pos_reg),
        .vel      (vel_reg),
        .cfg      (cfg),
        .pos_next (pos_next),
        .vel_next (vel_next)
    );

    // sample payload register
    always_ff @(posedge clk)
    begin
        if (take)
            raw_reg <= sample.raw_angle;
    end

    // control and observer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            pos_reg       <= '0;
            vel_reg       <= '0;
        end
        else
        begin
            if (sample.ready)
                smp_valid_reg <= sample.valid;
            if (advance)
            begin
                res_valid_reg <= smp_valid_reg;
                if (smp_valid_reg)
                begin
                    pos_reg <= pos_next;
                    vel_reg <= vel_next;
                end
            end
        end
    end

    // estimates straight from the state
    assign estimate.valid    = res_valid_reg;
    assign estimate.position = alo_pkg::POS_OUT_W'({{alo_pkg::POS_OUT_W{1'b0}},
                                                    pos_reg[PW-1 -: AW]});
    assign estimate.velocity = vel_reg;

endmodule

### tb/sv/angle_luenberger_observer_core_tb.sv
// self-checking testbench for the angle observer core: directed table, then tracked random
`timescale 1ns / 100ps

module angle_luenberger_observer_core_tb;
    import alo_pkg::*;

    localparam int FRAC_BITS      = 16;
    localparam int DRIFT_SHIFT    = 40 - (RAW_W + FRAC_BITS);
    localparam int PLAN_LEN       = 24;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 300;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 5000;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;

    typedef struct packed {
        logic [POS_OUT_W-1:0]    position;
        logic signed [VEL_W-1:0] velocity;
    } estimate_t;

    typedef struct packed {
        row_kind_t            kind;
        reg_idx_t             idx;
        logic [APB_DW-1:0]    value;
        logic [RAW_W-1:0]     raw;
        logic                 typed;
        logic [POS_OUT_W-1:0] want_pos;
        logic [VEL_W-1:0]     want_vel;
    } row_t;

    // directed rows; typed expectations only where they follow at a glance
    localparam row_t PLAN [PLAN_LEN] = '{
        // zero gains after reset: estimates stay at zero
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'h0000, 1'b1, 16'h0000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'hFFFF, 1'b1, 16'h0000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'h8000, 1'b1, 16'h0000, 32'h0},
        // full position gain, half-turn error goes the negative way
        '{ROW_WRITE,  REG_L1_GAIN,     32'h0000_FFFF,  16'h0000, 1'b0, 16'h0000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'h8000, 1'b1, 16'h8000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'h8000, 1'b1, 16'h8000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'h7FFF, 1'b1, 16'h7FFF, 32'h0},
        // half position gain, unit velocity gain, largest positive error
        '{ROW_WRITE,  REG_L1_GAIN,     32'h0000_8000,  16'h0000, 1'b0, 16'h0000, 32'h0},
        '{ROW_WRITE,  REG_L2_GAIN,     32'h0001_0000,  16'h0000, 1'b0, 16'h0000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'hFFFE, 1'b1, 16'hBFFF, 32'h7FFF},
        // top velocity gain clamps at the reset speed limit
        '{ROW_WRITE,  REG_L2_GAIN,     32'hFFFF_FFFF,  16'h0000, 1'b0, 16'h0000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'h3FFF, 1'b0, 16'h0000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'hFFFF, 1'b0, 16'h0000, 32'h0},
        // top step gain drives the position from the velocity
        '{ROW_WRITE,  REG_STEP_GAIN,   32'hFFFF_FFFF,  16'h0000, 1'b0, 16'h0000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'h0000, 1'b0, 16'h0000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'h1234, 1'b0, 16'h0000, 32'h0},
        // widest clamp
        '{ROW_WRITE,  REG_SPEED_LIMIT, 32'h7FFF_FFFF,  16'h0000, 1'b0, 16'h0000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'h8000, 1'b0, 16'h0000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'h0001, 1'b0, 16'h0000, 32'h0},
        // zero clamp forces the velocity to zero
        '{ROW_WRITE,  REG_SPEED_LIMIT, 32'h0000_0000,  16'h0000, 1'b0, 16'h0000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'hC000, 1'b0, 16'h0000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'h4000, 1'b0, 16'h0000, 32'h0},
        '{ROW_WRITE,  REG_STEP_GAIN,   32'h0000_0000,  16'h0000, 1'b0, 16'h0000, 32'h0},
        '{ROW_SAMPLE, REG_L1_GAIN,     32'h0,          16'h7FFF, 1'b0, 16'h0000, 32'h0}
    };

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    alo_in_if  sample_ch ();
    alo_out_if estimate_ch ();

    // tracked copy of the observer state and its settings
    logic [RAW_W+FRAC_BITS-1:0] angle_est     = '0;
    int                         speed_est     = 0;
    logic [L1_W-1:0]            l1_gain_q     = '0;
    logic [L2_W-1:0]            l2_gain_q     = '0;
    logic [STEP_W-1:0]          step_gain_q   = '0;
    logic [LIMIT_W-1:0]         speed_limit_q = SPEED_LIMIT_RST;

    estimate_t pending_est [$];
    int        errors        = 0;
    int        quiet_cycles  = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_reqs     = 0;
    int        hold_seen     = 0;
    int        hold_left     = 0;

    angle_luenberger_observer_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_ch),
        .estimate (estimate_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // one observer update: wrapped error, position step, clamped velocity
    function automatic void track_angle(input logic [RAW_W-1:0] raw, output estimate_t est);
        logic [RAW_W-1:0] diff;
        longint           err;
        longint           drift;
        longint           fix;
        longint           vnext;
        longint           lim;
        diff  = raw - angle_est[RAW_W+FRAC_BITS-1:FRAC_BITS];
        err   = longint'($signed(diff));
        drift = (longint'(speed_est) * longint'(step_gain_q)) >>> DRIFT_SHIFT;
        fix   = err * longint'(l1_gain_q);
        angle_est = angle_est + drift[RAW_W+FRAC_BITS-1:0] + fix[RAW_W+FRAC_BITS-1:0];
        vnext = longint'(speed_est) + ((err * longint'(l2_gain_q)) >>> 16);
        lim   = longint'(speed_limit_q);
        if (vnext > lim)
            vnext = lim;
        if (vnext < -lim)
            vnext = -lim;
        speed_est    = int'(vnext);
        est.position = angle_est[RAW_W+FRAC_BITS-1:FRAC_BITS];
        est.velocity = speed_est;
    endfunction

    function automatic logic [APB_DW-1:0] held_setting(input reg_idx_t idx);
        case (idx)
            REG_L1_GAIN:   return APB_DW'(l1_gain_q);
            REG_L2_GAIN:   return APB_DW'(l2_gain_q);
            REG_STEP_GAIN: return APB_DW'(step_gain_q);
            default:       return APB_DW'(speed_limit_q);
        endcase
    endfunction

    // mostly plausible observer settings, sometimes the extremes
    function automatic logic [31:0] pick_setting(input logic [31:0] typ_lo,
                                                 input logic [31:0] typ_hi,
                                                 input logic [31:0] top);
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return top;
            2:       return $urandom & top;
            default: return $urandom_range(typ_hi, typ_lo);
        endcase
    endfunction

    // register read back against the tracked copy
    task automatic check_reg(input reg_idx_t idx);
        logic [APB_DW-1:0] data;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (data !== held_setting(idx))
            report_mismatch($sformatf("register %s reads %h want %h",
                                      idx.name(), data, held_setting(idx)));
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_L1_GAIN:   l1_gain_q     = value[L1_W-1:0];
            REG_L2_GAIN:   l2_gain_q     = value[L2_W-1:0];
            REG_STEP_GAIN: step_gain_q   = value[STEP_W-1:0];
            default:       speed_limit_q = value[LIMIT_W-1:0];
        endcase
        check_reg(idx);
    endtask

    // offer one sample beat; valid stays high on return for back-to-back beats
    task automatic send_sample(input logic [RAW_W-1:0] raw, input logic typed,
                               input estimate_t want);
        estimate_t est;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.raw_angle <= raw;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        track_angle(raw, est);
        pending_est.push_back(typed ? want : est);
        @(negedge clk);
    endtask

    // stop offering and wait for every outstanding estimate
    task automatic drain_estimates();
        sample_ch.valid <= 1'b0;
        while (pending_est.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // estimate receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            estimate_ch.ready <= 1'b0;
        end
        else
            estimate_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each estimate beat with the oldest prediction
    always @(posedge clk)
    begin
        estimate_t want;
        if (rst_n && estimate_ch.valid === 1'b1 && estimate_ch.ready === 1'b1)
        begin
            if (pending_est.size() == 0)
                report_mismatch("estimate beat with nothing outstanding");
            else
            begin
                want = pending_est.pop_front();
                if (estimate_ch.position !== want.position)
                    report_mismatch($sformatf("position got %h want %h",
                                              estimate_ch.position, want.position));
                if (estimate_ch.velocity !== want.velocity)
                    report_mismatch($sformatf("velocity got %0d want %0d",
                                              estimate_ch.velocity, want.velocity));
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
            (estimate_ch.valid === 1'b1 && estimate_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        row_t             row;
        logic [RAW_W-1:0] raw;
        logic [31:0]      true_angle;
        int               turn_rate;

        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.raw_angle = '0;
        true_angle          = $urandom;
        turn_rate           = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register defaults after reset
        for (int i = 0; i < 4; i++)
            check_reg(reg_idx_t'(i));

        // directed table
        send_idle_pct = 38;
        recv_idle_pct = 74;
        for (int r = 0; r < PLAN_LEN; r++)
        begin
            row = PLAN[r];
            if (row.kind == ROW_WRITE)
            begin
                drain_estimates();
                write_reg(row.idx, row.value);
            end
            else
                send_sample(row.raw, row.typed, {row.want_pos, row.want_vel});
        end

        // random phases: receiver idles more, then sender idles more, then neither
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_estimates();
            case (ph / 2)
                0:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 74;
                end
                1:
                begin
                    send_idle_pct = 74;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_reg(REG_L1_GAIN, pick_setting(32'h0800, 32'h8000, 32'h0000_FFFF));
            write_reg(REG_L2_GAIN, pick_setting(32'h1000, 32'h40_0000, 32'hFFFF_FFFF));
            write_reg(REG_STEP_GAIN, pick_setting(32'd2000, 32'd200000, 32'hFFFF_FFFF));
            write_reg(REG_SPEED_LIMIT,
                      pick_setting(32'd100000, 32'h1000_0000, 32'h7FFF_FFFF));

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while samples keep coming, later a full pause
                if (ph == PRESSURE_PHASE && n == 100)
                    hold_reqs++;
                if (ph == PRESSURE_PHASE && n == 200)
                    drain_estimates();

                // mostly a noisy rotating encoder, sometimes a stray reading
                if ($urandom_range(99) < 20)
                    raw = RAW_W'($urandom);
                else
                begin
                    if ($urandom_range(63) == 0 || n == 0)
                        turn_rate = $signed($urandom) >>> $urandom_range(22, 3);
                    true_angle = true_angle + turn_rate;
                    raw = true_angle[31:16] + RAW_W'($urandom_range(15)) - RAW_W'(8);
                end
                send_sample(raw, 1'b0, '0);
            end
        end

        drain_estimates();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
